// ===== rtl/core/mbb_pkg.sv =====
// Shared types, codes and default sizes for the monotone basin search block.
// No dependencies; the RTL uses scoped names, the testbench imports it.
package mbb_pkg;

   localparam int MAX_VERTICES_DEFAULT = 1024;
   localparam int MAX_DEGREE_DEFAULT   = 16;

   localparam int VERTEX_FIELD_W = 10;
   localparam int HOP_FIELD_W    = 10;

   typedef logic signed [63:0] weight_type;
   typedef logic [VERTEX_FIELD_W-1:0] vertex_field_type;

   // request commands
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_START  = 2'd2;
   localparam logic [1:0] CMD_READ   = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_SUMMARY = 2'd0;
   localparam logic [1:0] KIND_BASIN   = 2'd1;
   localparam logic [1:0] KIND_HOP     = 2'd2;
   localparam logic [1:0] KIND_SPAN    = 2'd3;

   // readout phases
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_SUMMARY = 3'd1;
   localparam logic [2:0] PH_BASIN   = 3'd2;
   localparam logic [2:0] PH_HOPTAB  = 3'd3;
   localparam logic [2:0] PH_SPANTAB = 3'd4;

endpackage

// ===== rtl/core/mbb_if.sv =====
// Channel interfaces of the monotone basin search block: request, response, csr.
// Depends on mbb_pkg for field types.
interface mbb_req_if;
   logic                     valid;
   logic                     ready;
   logic [1:0]               command;
   mbb_pkg::vertex_field_type vertex_id;
   mbb_pkg::vertex_field_type neighbor_id;
   logic [31:0]              density;
   logic signed [31:0]       fitted_value;
   modport source (output valid, command, vertex_id, neighbor_id, density, fitted_value,
                   input ready);
   modport sink   (input valid, command, vertex_id, neighbor_id, density, fitted_value,
                   output ready);
endinterface

interface mbb_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                item_kind;
   mbb_pkg::vertex_field_type out_vertex;
   logic                      vertex_valid;
   logic [mbb_pkg::HOP_FIELD_W-1:0] out_hop;
   mbb_pkg::weight_type       out_span;
   logic                      span_valid;
   logic                      last_item;
   logic                      error_flag;
   modport source (output valid, item_kind, out_vertex, vertex_valid, out_hop, out_span,
                   span_valid, last_item, error_flag, input ready);
   modport sink   (input valid, item_kind, out_vertex, vertex_valid, out_hop, out_span,
                   span_valid, last_item, error_flag, output ready);
endinterface

interface mbb_csr_if;
   logic valid;
   logic ready;
   logic find_maximum;
   modport source (output valid, find_maximum, input ready);
   modport sink   (input valid, find_maximum, output ready);
endinterface

// ===== rtl/core/mbb_span.sv =====
// Span unit: saturating difference of a weight against the seed weight.
// Depends on mbb_pkg for the weight type.
module mbb_span (
   input  logic                find_maximum,
   input  mbb_pkg::weight_type seed_weight,
   input  mbb_pkg::weight_type weight,
   output mbb_pkg::weight_type span,
   output logic                positive
);
   mbb_pkg::weight_type a;
   mbb_pkg::weight_type b;
   logic signed [64:0]  diff;

   always_comb begin
      a = find_maximum ? seed_weight : weight;
      b = find_maximum ? weight : seed_weight;
      diff = {a[63], a} - {b[63], b};
      // clip on overflow of the 64-bit result
      if (diff[64] != diff[63]) begin
         span = diff[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         span = diff[63:0];
      end
      positive = !span[63] && (span != '0);
   end
endmodule

// ===== rtl/core/monotone_basin_bfs.sv =====
// Monotone basin search: top level with its graph and search memories.
// Depends on mbb_pkg, the channel interfaces in mbb_if and mbb_span.
//
// Usage: requests arrive on req_ch (valid/ready). Load vertex writes the
// weight (density clamped to 1 LSB, times fitted value) and clears the list;
// append edge adds a neighbor; start runs a breadth-first search from the
// seed; read returns the next result item on rsp_ch. csr_ch writes
// find_maximum (always ready); the user must write it only while the
// block is idle, which the block itself does not enforce. A read may scan
// the hop and span tables past unset entries. Start runs a clearing pass
// over all vertices, then the search and a boundary pass; each memory has
// a single read port. Reset starts a clearing pass over the degree store
// and the search memories; no request is taken until it ends. One request
// is in flight at a time: ready stays low while a response waits, so a
// stalled receiver holds the response register and the request side.
module monotone_basin_bfs #(
   parameter int MAX_VERTICES = mbb_pkg::MAX_VERTICES_DEFAULT,
   parameter int MAX_DEGREE   = mbb_pkg::MAX_DEGREE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   mbb_req_if.sink     req_ch,
   mbb_rsp_if.source   rsp_ch,
   mbb_csr_if.sink     csr_ch
);
   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int CW  = VW + 1;
   localparam int DGW = $clog2(MAX_DEGREE + 1);
   localparam int AW  = $clog2(MAX_VERTICES * MAX_DEGREE);
   localparam int HW  = VW + 1;   // visited bit on top of the hop
   localparam logic [VW-1:0] LAST_V = VW'(MAX_VERTICES - 1);

   localparam logic [4:0] S_CLEAR = 5'd0,  S_IDLE  = 5'd1,  S_LOAD  = 5'd2,
                          S_LOADW = 5'd3,  S_APP1  = 5'd4,  S_APP2  = 5'd5,
                          S_SEED  = 5'd6,  S_SEED2 = 5'd7,  S_POP   = 5'd8,
                          S_POP2  = 5'd9,  S_POP3  = 5'd10, S_CHK   = 5'd11,
                          S_VIOL  = 5'd12, S_EXP   = 5'd13, S_EXP2  = 5'd14,
                          S_EXP3  = 5'd15, S_B0    = 5'd16, S_B1    = 5'd17,
                          S_B2    = 5'd18, S_BE    = 5'd19, S_BE2   = 5'd20,
                          S_BE3   = 5'd21, S_BW    = 5'd22, S_RS0   = 5'd23,
                          S_RS1   = 5'd24, S_RB0   = 5'd25, S_RB1   = 5'd26,
                          S_RB2   = 5'd27, S_SK0   = 5'd28, S_SK1   = 5'd29;

   // ---------------- memories ----------------
   logic [VW-1:0]          adj_mem_ff   [MAX_VERTICES*MAX_DEGREE];
   logic [DGW-1:0]         deg_mem_ff   [MAX_VERTICES];
   mbb_pkg::weight_type    wgt_mem_ff   [MAX_VERTICES];
   logic [HW-1:0]          hop_mem_ff   [MAX_VERTICES];
   logic [VW-1:0]          pred_mem_ff  [MAX_VERTICES];
   logic                   inb_mem_ff   [MAX_VERTICES];
   logic [VW-1:0]          queue_mem_ff [MAX_VERTICES];
   logic [VW-1:0]          order_mem_ff [MAX_VERTICES];
   logic [VW-1:0]          lvlf_mem_ff  [MAX_VERTICES];
   logic [VW:0]            hbt_mem_ff   [MAX_VERTICES];
   logic [64:0]            spt_mem_ff   [MAX_VERTICES];

   logic adj_we, deg_we, wgt_we, hop_we, pred_we, inb_we, queue_we, order_we, lvlf_we;
   logic hbt_we, spt_we;
   logic [AW-1:0] adj_wa, adj_ra;
   logic [VW-1:0] deg_wa, deg_ra, wgt_wa, wgt_ra, hop_wa, hop_ra, pred_wa, pred_ra;
   logic [VW-1:0] inb_wa, inb_ra, queue_wa, queue_ra, order_wa, order_ra;
   logic [VW-1:0] lvlf_wa, lvlf_ra, hbt_wa, hbt_ra, spt_wa, spt_ra;
   logic [VW-1:0] adj_wd, pred_wd, queue_wd, order_wd, lvlf_wd;
   logic [DGW-1:0] deg_wd;
   mbb_pkg::weight_type wgt_wd;
   logic [HW-1:0] hop_wd;
   logic inb_wd;
   logic [VW:0] hbt_wd;
   logic [64:0] spt_wd;

   logic [VW-1:0]       adj_q_ff, pred_q_ff, queue_q_ff, order_q_ff, lvlf_q_ff;
   logic [DGW-1:0]      deg_q_ff;
   mbb_pkg::weight_type wgt_q_ff;
   logic [HW-1:0]       hop_q_ff;
   logic                inb_q_ff;
   logic [VW:0]         hbt_q_ff;
   logic [64:0]         spt_q_ff;

   always_ff @(posedge clock) begin
      if (adj_we) adj_mem_ff[adj_wa] <= adj_wd;
      adj_q_ff <= adj_mem_ff[adj_ra];
   end
   always_ff @(posedge clock) begin
      if (deg_we) deg_mem_ff[deg_wa] <= deg_wd;
      deg_q_ff <= deg_mem_ff[deg_ra];
   end
   always_ff @(posedge clock) begin
      if (wgt_we) wgt_mem_ff[wgt_wa] <= wgt_wd;
      wgt_q_ff <= wgt_mem_ff[wgt_ra];
   end
   always_ff @(posedge clock) begin
      if (hop_we) hop_mem_ff[hop_wa] <= hop_wd;
      hop_q_ff <= hop_mem_ff[hop_ra];
   end
   always_ff @(posedge clock) begin
      if (pred_we) pred_mem_ff[pred_wa] <= pred_wd;
      pred_q_ff <= pred_mem_ff[pred_ra];
   end
   always_ff @(posedge clock) begin
      if (inb_we) inb_mem_ff[inb_wa] <= inb_wd;
      inb_q_ff <= inb_mem_ff[inb_ra];
   end
   always_ff @(posedge clock) begin
      if (queue_we) queue_mem_ff[queue_wa] <= queue_wd;
      queue_q_ff <= queue_mem_ff[queue_ra];
   end
   always_ff @(posedge clock) begin
      if (order_we) order_mem_ff[order_wa] <= order_wd;
      order_q_ff <= order_mem_ff[order_ra];
   end
   always_ff @(posedge clock) begin
      if (lvlf_we) lvlf_mem_ff[lvlf_wa] <= lvlf_wd;
      lvlf_q_ff <= lvlf_mem_ff[lvlf_ra];
   end
   always_ff @(posedge clock) begin
      if (hbt_we) hbt_mem_ff[hbt_wa] <= hbt_wd;
      hbt_q_ff <= hbt_mem_ff[hbt_ra];
   end
   always_ff @(posedge clock) begin
      if (spt_we) spt_mem_ff[spt_wa] <= spt_wd;
      spt_q_ff <= spt_mem_ff[spt_ra];
   end

   // ---------------- registers ----------------
   logic [4:0]   state_ff, state_in;
   logic         clr_all_ff, clr_all_in;
   logic [VW-1:0] clr_cnt_ff, clr_cnt_in;
   logic         find_max_ff;
   logic [1:0]   cmd_ff, cmd_in;
   logic [VW-1:0] vid_ff, vid_in, nid_ff, nid_in;
   logic         vok_ff, vok_in, nok_ff, nok_in;
   logic [31:0]  dens_ff, dens_in;
   logic signed [31:0] fv_ff, fv_in;
   mbb_pkg::weight_type prod_ff, prod_in;
   logic [VW-1:0] seed_ff, seed_in;
   mbb_pkg::weight_type seed_w_ff, seed_w_in;
   logic [CW-1:0] head_ff, head_in, tail_ff, tail_in, bsize_ff, bsize_in;
   logic [CW-1:0] idx_ff, idx_in, gstart_ff, gstart_in, gend_ff, gend_in;
   logic [VW-1:0] u_ff, u_in, p_ff, p_in, v_ff, v_in;
   logic [VW-1:0] hop_u_ff, hop_u_in, hop_p_ff, hop_p_in;
   logic [DGW-1:0] degu_ff, degu_in, j_ff, j_in;
   mbb_pkg::weight_type wu_ff, wu_in, span_ff, span_in;
   logic         span_pos_ff, span_pos_in;
   logic [VW-1:0] last_hop_ff, last_hop_in, maxhop_ff, maxhop_in, lvl_ff, lvl_in;
   logic         least_valid_ff, least_valid_in;
   logic [VW-1:0] least_vertex_ff, least_vertex_in;
   mbb_pkg::weight_type least_span_ff, least_span_in;
   logic [2:0]   phase_ff, phase_in;
   logic [VW-1:0] cur_ff, cur_in, found_v_ff, found_v_in, found_hop_ff, found_hop_in;
   mbb_pkg::weight_type found_span_ff, found_span_in;
   logic [1:0]   r_kind_ff, r_kind_in;
   logic [9:0]   r_vertex_ff, r_vertex_in, r_hop_ff, r_hop_in;
   logic         r_vvalid_ff, r_vvalid_in, r_svalid_ff, r_svalid_in;
   logic         r_last_ff, r_last_in, r_err_ff, r_err_in, r_valid_ff, r_valid_in;
   mbb_pkg::weight_type r_span_ff, r_span_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   mbb_pkg::weight_type span_w;
   logic span_pos_w;
   logic weight_ok;
   logic req_fire;

   mbb_span u_mbb_span (
      .find_maximum (find_max_ff),
      .seed_weight  (seed_w_ff),
      .weight       (wgt_q_ff),
      .span         (span_w),
      .positive     (span_pos_w)
   );

   assign req_ch.ready = (state_ff == S_IDLE) && !r_valid_ff;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid        = r_valid_ff;
   assign rsp_ch.item_kind    = r_kind_ff;
   assign rsp_ch.out_vertex   = r_vertex_ff;
   assign rsp_ch.vertex_valid = r_vvalid_ff;
   assign rsp_ch.out_hop      = r_hop_ff;
   assign rsp_ch.out_span     = r_span_ff;
   assign rsp_ch.span_valid   = r_svalid_ff;
   assign rsp_ch.last_item    = r_last_ff;
   assign rsp_ch.error_flag   = r_err_ff;

   always_comb begin
      mul_a = {fv_ff[31], fv_ff};
      mul_b = {1'b0, (dens_ff == '0) ? 32'd1 : dens_ff};
      mul_p = mul_a * mul_b;
      // a reached vertex must move strictly away from the extremum
      weight_ok = find_max_ff ? (wu_ff < wgt_q_ff) : (wu_ff > wgt_q_ff);
   end

   always_comb begin
      state_in = state_ff;        clr_all_in = clr_all_ff;  clr_cnt_in = clr_cnt_ff;
      cmd_in = cmd_ff;            vid_in = vid_ff;          nid_in = nid_ff;
      vok_in = vok_ff;            nok_in = nok_ff;          dens_in = dens_ff;
      fv_in = fv_ff;              prod_in = prod_ff;        seed_in = seed_ff;
      seed_w_in = seed_w_ff;      head_in = head_ff;        tail_in = tail_ff;
      bsize_in = bsize_ff;        idx_in = idx_ff;          gstart_in = gstart_ff;
      gend_in = gend_ff;          u_in = u_ff;              p_in = p_ff;
      v_in = v_ff;                hop_u_in = hop_u_ff;      hop_p_in = hop_p_ff;
      degu_in = degu_ff;          j_in = j_ff;              wu_in = wu_ff;
      span_in = span_ff;          span_pos_in = span_pos_ff;
      last_hop_in = last_hop_ff;  maxhop_in = maxhop_ff;    lvl_in = lvl_ff;
      least_valid_in = least_valid_ff; least_vertex_in = least_vertex_ff;
      least_span_in = least_span_ff;   phase_in = phase_ff; cur_in = cur_ff;
      found_v_in = found_v_ff;    found_hop_in = found_hop_ff; found_span_in = found_span_ff;
      r_kind_in = r_kind_ff;      r_vertex_in = r_vertex_ff; r_hop_in = r_hop_ff;
      r_vvalid_in = r_vvalid_ff;  r_svalid_in = r_svalid_ff; r_last_in = r_last_ff;
      r_err_in = r_err_ff;        r_span_in = r_span_ff;
      r_valid_in = r_valid_ff && !rsp_ch.ready;

      adj_we = 1'b0;   adj_wa = AW'(vid_ff) * AW'(MAX_DEGREE) + AW'(deg_q_ff);
      adj_wd = nid_ff; adj_ra = AW'(u_ff) * AW'(MAX_DEGREE) + AW'(j_ff);
      deg_we = 1'b0;   deg_wa = vid_ff;  deg_wd = '0;  deg_ra = vid_ff;
      wgt_we = 1'b0;   wgt_wa = vid_ff;  wgt_wd = prod_ff; wgt_ra = u_ff;
      hop_we = 1'b0;   hop_wa = v_ff;    hop_wd = {1'b1, VW'(hop_u_ff + 1'b1)};
      hop_ra = u_ff;
      pred_we = 1'b0;  pred_wa = v_ff;   pred_wd = u_ff;  pred_ra = u_ff;
      inb_we = 1'b0;   inb_wa = u_ff;    inb_wd = 1'b1;   inb_ra = adj_q_ff;
      queue_we = 1'b0; queue_wa = VW'(tail_ff); queue_wd = v_ff; queue_ra = VW'(head_ff);
      order_we = 1'b0; order_wa = VW'(bsize_ff); order_wd = u_ff; order_ra = VW'(idx_ff);
      lvlf_we = 1'b0;  lvlf_wa = hop_u_ff; lvlf_wd = VW'(bsize_ff); lvlf_ra = maxhop_ff;
      hbt_we = 1'b0;   hbt_wa = hop_u_ff; hbt_wd = {1'b1, u_ff}; hbt_ra = cur_ff;
      spt_we = 1'b0;   spt_wa = u_ff;    spt_wd = {1'b1, span_ff}; spt_ra = cur_ff;

      unique case (state_ff)
         S_CLEAR: begin
            // wipe visit marks, basin flags and both tables; degrees after reset
            hop_we = 1'b1;  hop_wa = clr_cnt_ff;  hop_wd = '0;
            inb_we = 1'b1;  inb_wa = clr_cnt_ff;  inb_wd = 1'b0;
            hbt_we = 1'b1;  hbt_wa = clr_cnt_ff;  hbt_wd = '0;
            spt_we = 1'b1;  spt_wa = clr_cnt_ff;  spt_wd = '0;
            deg_we = clr_all_ff; deg_wa = clr_cnt_ff; deg_wd = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LAST_V) begin
               clr_cnt_in = '0;
               state_in   = clr_all_ff ? S_IDLE : S_SEED;
               clr_all_in = 1'b0;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               cmd_in  = req_ch.command;
               vid_in  = VW'(req_ch.vertex_id);
               nid_in  = VW'(req_ch.neighbor_id);
               vok_in  = 32'(req_ch.vertex_id) < 32'(MAX_VERTICES);
               nok_in  = 32'(req_ch.neighbor_id) < 32'(MAX_VERTICES);
               dens_in = req_ch.density;
               fv_in   = req_ch.fitted_value;
               r_kind_in = mbb_pkg::KIND_SUMMARY;  r_vertex_in = '0;  r_hop_in = '0;
               r_vvalid_in = 1'b0; r_svalid_in = 1'b0; r_span_in = '0;
               r_last_in = 1'b0;   r_err_in = 1'b0;
               case (req_ch.command)
                  mbb_pkg::CMD_LOAD:   state_in = S_LOAD;
                  mbb_pkg::CMD_APPEND: state_in = S_APP1;
                  mbb_pkg::CMD_START: begin
                     if (32'(req_ch.vertex_id) < 32'(MAX_VERTICES)) begin
                        seed_in    = VW'(req_ch.vertex_id);
                        phase_in   = mbb_pkg::PH_IDLE;
                        clr_cnt_in = '0;
                        state_in   = S_CLEAR;
                     end
                  end
                  default: begin
                     case (phase_ff)
                        mbb_pkg::PH_IDLE: begin
                           r_err_in = 1'b1;  r_valid_in = 1'b1;
                        end
                        mbb_pkg::PH_SUMMARY: begin
                           r_vertex_in = least_valid_ff ? 10'(least_vertex_ff) : '0;
                           r_vvalid_in = least_valid_ff;
                           r_span_in   = seed_w_ff;
                           r_svalid_in = 1'b1;
                           r_valid_in  = 1'b1;
                           phase_in    = mbb_pkg::PH_BASIN;
                        end
                        mbb_pkg::PH_BASIN: state_in = S_RB0;
                        mbb_pkg::PH_HOPTAB: begin
                           r_kind_in = mbb_pkg::KIND_HOP;  r_vvalid_in = 1'b1;
                           r_vertex_in = 10'(found_v_ff);  r_hop_in = 10'(cur_ff);
                           if (cur_ff == LAST_V) begin
                              phase_in = mbb_pkg::PH_SPANTAB;  cur_in = '0;
                           end else begin
                              cur_in = cur_ff + 1'b1;
                           end
                           state_in = S_SK0;
                        end
                        default: begin
                           r_kind_in = mbb_pkg::KIND_SPAN;  r_vvalid_in = 1'b1;
                           r_vertex_in = 10'(cur_ff);  r_hop_in = 10'(found_hop_ff);
                           r_span_in = found_span_ff;  r_svalid_in = 1'b1;
                           if (cur_ff == LAST_V) begin
                              phase_in = mbb_pkg::PH_IDLE;  cur_in = '0;
                           end else begin
                              cur_in = cur_ff + 1'b1;
                           end
                           state_in = S_SK0;
                        end
                     endcase
                  end
               endcase
            end
         end
         S_LOAD: begin
            prod_in  = mul_p[63:0];
            state_in = vok_ff ? S_LOADW : S_IDLE;
         end
         S_LOADW: begin
            wgt_we = 1'b1;  deg_we = 1'b1;  deg_wd = '0;
            state_in = S_IDLE;
         end
         S_APP1: begin
            state_in = (vok_ff && nok_ff) ? S_APP2 : S_IDLE;
         end
         S_APP2: begin
            if (deg_q_ff >= DGW'(MAX_DEGREE)) begin
               // full list: drop the edge and flag it
               r_err_in = 1'b1;  r_valid_in = 1'b1;
            end else begin
               adj_we = 1'b1;
               deg_we = 1'b1;  deg_wd = deg_q_ff + 1'b1;
            end
            state_in = S_IDLE;
         end
         S_SEED: begin
            wgt_ra = seed_ff;
            hop_we = 1'b1;   hop_wa = seed_ff;   hop_wd = {1'b1, {VW{1'b0}}};
            pred_we = 1'b1;  pred_wa = seed_ff;  pred_wd = seed_ff;
            inb_we = 1'b1;   inb_wa = seed_ff;
            queue_we = 1'b1; queue_wa = '0;      queue_wd = seed_ff;
            order_we = 1'b1; order_wa = '0;      order_wd = seed_ff;
            lvlf_we = 1'b1;  lvlf_wa = '0;       lvlf_wd = '0;
            head_in = '0;  tail_in = CW'(1);  bsize_in = CW'(1);
            last_hop_in = '0;  maxhop_in = '0;
            least_valid_in = 1'b0;  least_vertex_in = '0;  least_span_in = '0;
            state_in = S_SEED2;
         end
         S_SEED2: begin
            seed_w_in = wgt_q_ff;
            state_in  = S_POP;
         end
         S_POP: begin
            if (head_ff == tail_ff) begin
               idx_in   = '0;
               state_in = S_B0;
            end else begin
               head_in  = head_ff + 1'b1;
               state_in = S_POP2;
            end
         end
         S_POP2: begin
            u_in = queue_q_ff;
            hop_ra = queue_q_ff;  pred_ra = queue_q_ff;
            wgt_ra = queue_q_ff;  deg_ra = queue_q_ff;
            state_in = S_POP3;
         end
         S_POP3: begin
            hop_u_in = hop_q_ff[VW-1:0];
            p_in     = pred_q_ff;
            wu_in    = wgt_q_ff;
            degu_in  = deg_q_ff;
            j_in     = '0;
            wgt_ra   = pred_q_ff;
            hop_ra   = pred_q_ff;
            state_in = (u_ff == seed_ff) ? S_EXP : S_CHK;
         end
         S_CHK: begin
            if (!weight_ok) begin
               span_in     = span_w;
               span_pos_in = span_pos_w;
               hop_p_in    = hop_q_ff[VW-1:0];
               state_in    = S_VIOL;
            end else begin
               inb_we = 1'b1;  order_we = 1'b1;
               bsize_in = bsize_ff + 1'b1;
               if (hop_u_ff != last_hop_ff) begin
                  // first basin vertex of a new hop level
                  lvlf_we = 1'b1;
                  last_hop_in = hop_u_ff;
                  maxhop_in   = hop_u_ff;
               end
               state_in = S_EXP;
            end
         end
         S_VIOL: begin
            spt_we = 1'b1;  spt_wa = p_ff;
            hbt_we = 1'b1;  hbt_wa = hop_p_ff;  hbt_wd = {1'b1, p_ff};
            if (span_pos_ff && (!least_valid_ff || span_ff < least_span_ff)) begin
               least_valid_in  = 1'b1;
               least_span_in   = span_ff;
               least_vertex_in = p_ff;
            end
            state_in = S_POP;
         end
         S_EXP: begin
            state_in = (j_ff == degu_ff) ? S_POP : S_EXP2;
         end
         S_EXP2: begin
            v_in     = adj_q_ff;
            hop_ra   = adj_q_ff;
            state_in = S_EXP3;
         end
         S_EXP3: begin
            if (!hop_q_ff[VW]) begin
               hop_we = 1'b1;  pred_we = 1'b1;  queue_we = 1'b1;
               tail_in = tail_ff + 1'b1;
            end
            j_in     = j_ff + 1'b1;
            state_in = S_EXP;
         end
         S_B0: begin
            state_in = (idx_ff == bsize_ff) ? S_RS0 : S_B1;
         end
         S_B1: begin
            u_in   = order_q_ff;
            deg_ra = order_q_ff;  hop_ra = order_q_ff;  wgt_ra = order_q_ff;
            state_in = S_B2;
         end
         S_B2: begin
            degu_in  = deg_q_ff;
            hop_u_in = hop_q_ff[VW-1:0];
            span_in  = span_w;
            j_in     = '0;
            state_in = (deg_q_ff == DGW'(1)) ? S_BW : S_BE;
         end
         S_BE: begin
            if (j_ff == degu_ff) begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_B0;
            end else begin
               state_in = S_BE2;
            end
         end
         S_BE2: begin
            state_in = S_BE3;
         end
         S_BE3: begin
            if (!inb_q_ff) begin
               state_in = S_BW;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_BE;
            end
         end
         S_BW: begin
            hbt_we = 1'b1;  spt_we = 1'b1;
            idx_in   = idx_ff + 1'b1;
            state_in = S_B0;
         end
         S_RS0: begin
            state_in = S_RS1;
         end
         S_RS1: begin
            // readout starts at the deepest hop level
            idx_in    = CW'(lvlf_q_ff);
            gstart_in = CW'(lvlf_q_ff);
            gend_in   = bsize_ff;
            lvl_in    = maxhop_ff;
            phase_in  = mbb_pkg::PH_SUMMARY;
            state_in  = S_IDLE;
         end
         S_RB0: begin
            state_in = S_RB1;
         end
         S_RB1: begin
            r_kind_in   = mbb_pkg::KIND_BASIN;
            r_vertex_in = 10'(order_q_ff);
            r_vvalid_in = 1'b1;
            r_hop_in    = 10'(lvl_ff);
            if (CW'(idx_ff + 1'b1) != gend_ff) begin
               idx_in     = idx_ff + 1'b1;
               r_valid_in = 1'b1;
               state_in   = S_IDLE;
            end else if (lvl_ff != '0) begin
               gend_in  = gstart_ff;
               lvl_in   = lvl_ff - 1'b1;
               lvlf_ra  = lvl_ff - 1'b1;
               state_in = S_RB2;
            end else begin
               phase_in = mbb_pkg::PH_HOPTAB;
               cur_in   = '0;
               state_in = S_SK0;
            end
         end
         S_RB2: begin
            idx_in     = CW'(lvlf_q_ff);
            gstart_in  = CW'(lvlf_q_ff);
            r_valid_in = 1'b1;
            state_in   = S_IDLE;
         end
         S_SK0: begin
            hop_ra = cur_ff;
            if (phase_ff == mbb_pkg::PH_IDLE) begin
               r_last_in  = 1'b1;
               r_valid_in = 1'b1;
               state_in   = S_IDLE;
            end else begin
               state_in = S_SK1;
            end
         end
         S_SK1: begin
            if (phase_ff == mbb_pkg::PH_HOPTAB) begin
               if (hbt_q_ff[VW]) begin
                  found_v_in = hbt_q_ff[VW-1:0];
                  r_valid_in = 1'b1;
                  state_in   = S_IDLE;
               end else if (cur_ff == LAST_V) begin
                  phase_in = mbb_pkg::PH_SPANTAB;  cur_in = '0;  state_in = S_SK0;
               end else begin
                  cur_in = cur_ff + 1'b1;  state_in = S_SK0;
               end
            end else begin
               if (spt_q_ff[64]) begin
                  found_span_in = spt_q_ff[63:0];
                  found_hop_in  = hop_q_ff[VW-1:0];
                  r_valid_in    = 1'b1;
                  state_in      = S_IDLE;
               end else if (cur_ff == LAST_V) begin
                  phase_in = mbb_pkg::PH_IDLE;  cur_in = '0;  state_in = S_SK0;
               end else begin
                  cur_in = cur_ff + 1'b1;  state_in = S_SK0;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_all_ff <= 1'b1;
         clr_cnt_ff <= '0;
         phase_ff   <= mbb_pkg::PH_IDLE;
         cur_ff     <= '0;
         r_valid_ff <= 1'b0;
         find_max_ff <= 1'b1;
         least_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_all_ff <= clr_all_in;
         clr_cnt_ff <= clr_cnt_in;
         phase_ff   <= phase_in;
         cur_ff     <= cur_in;
         r_valid_ff <= r_valid_in;
         least_valid_ff <= least_valid_in;
         if (csr_ch.valid) find_max_ff <= csr_ch.find_maximum;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;        vid_ff <= vid_in;        nid_ff <= nid_in;
      vok_ff <= vok_in;        nok_ff <= nok_in;        dens_ff <= dens_in;
      fv_ff <= fv_in;          prod_ff <= prod_in;      seed_ff <= seed_in;
      seed_w_ff <= seed_w_in;  head_ff <= head_in;      tail_ff <= tail_in;
      bsize_ff <= bsize_in;    idx_ff <= idx_in;        gstart_ff <= gstart_in;
      gend_ff <= gend_in;      u_ff <= u_in;            p_ff <= p_in;
      v_ff <= v_in;            hop_u_ff <= hop_u_in;    hop_p_ff <= hop_p_in;
      degu_ff <= degu_in;      j_ff <= j_in;            wu_ff <= wu_in;
      span_ff <= span_in;      span_pos_ff <= span_pos_in;
      last_hop_ff <= last_hop_in; maxhop_ff <= maxhop_in; lvl_ff <= lvl_in;
      least_vertex_ff <= least_vertex_in; least_span_ff <= least_span_in;
      found_v_ff <= found_v_in; found_hop_ff <= found_hop_in;
      found_span_ff <= found_span_in;
      r_kind_ff <= r_kind_in;  r_vertex_ff <= r_vertex_in; r_hop_ff <= r_hop_in;
      r_vvalid_ff <= r_vvalid_in; r_svalid_ff <= r_svalid_in; r_last_ff <= r_last_in;
      r_err_ff <= r_err_in;    r_span_ff <= r_span_in;
   end

endmodule

// ===== rtl/core/mbb_checker.sv =====
// Port-level checks of the monotone basin search block, bound to its top level.
// Depends on mbb_pkg for the result kind codes.
module mbb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  item_kind,
   input logic        vertex_valid,
   input logic [9:0]  out_hop,
   input logic        span_valid,
   input logic        last_item,
   input logic        error_flag
);
   // drop any response across reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // hold off new requests while a response waits
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while response pending");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && error_flag |->
         item_kind == mbb_pkg::KIND_SUMMARY && !vertex_valid && !span_valid && !last_item)
      else $error("error response carries data");

   a_summary_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !error_flag && item_kind == mbb_pkg::KIND_SUMMARY |->
         span_valid && out_hop == '0 && !last_item)
      else $error("malformed summary");

   a_basin_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (item_kind == mbb_pkg::KIND_BASIN || item_kind == mbb_pkg::KIND_HOP) |->
         vertex_valid && !span_valid && !error_flag)
      else $error("malformed basin or hop item");
endmodule

bind monotone_basin_bfs mbb_checker u_mbb_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .item_kind    (rsp_ch.item_kind),
   .vertex_valid (rsp_ch.vertex_valid),
   .out_hop      (rsp_ch.out_hop),
   .span_valid   (rsp_ch.span_valid),
   .last_item    (rsp_ch.last_item),
   .error_flag   (rsp_ch.error_flag)
);

// ===== test/monotone_basin_bfs_tb.sv =====
// Testbench for monotone_basin_bfs: graph loads, searches and readouts are checked
// against a behavioral predictor held in a scoreboard class.
// Depends on mbb_pkg, the channel interfaces in mbb_if and the block itself.
module monotone_basin_bfs_tb;
   import mbb_pkg::*;

   localparam int NV         = 1024;
   localparam int ND         = 16;
   localparam int IDLE_PCT   = 37;
   localparam int ITEM_GOAL  = 1600;
   localparam int CYCLE_CAP  = 4000000;
   localparam int UNREACHED  = -1;

   typedef struct packed {
      logic [1:0]         kind;
      logic [9:0]         vert;
      logic               vert_ok;
      logic [9:0]         hop;
      logic signed [63:0] span;
      logic               span_ok;
      logic               last;
      logic               err;
   } basin_item_t;

   // Predictor of the basin search plus the store of expected responses.
   class basin_scoreboard;
      logic [9:0]  adj [NV][ND];
      int          deg [NV];
      longint      wt [NV];
      int          hop [NV];
      int          pred [NV];
      bit          in_basin [NV];
      bit          hb_ok [NV];
      int          hb_vert [NV];
      bit          sp_ok [NV];
      longint      sp_val [NV];
      bit          max_mode;
      basin_item_t readout [$];
      basin_item_t expected [$];
      int          mismatches;

      function new();
         max_mode = 1'b1;
         mismatches = 0;
         foreach (deg[i]) begin
            deg[i] = 0;
            wt[i] = 0;
            hop[i] = UNREACHED;
         end
      endfunction

      function basin_item_t mk(logic [1:0] k, int v, bit vo, int h, longint s, bit so,
                               bit e);
         basin_item_t it;
         it.kind = k;
         it.vert = 10'(v);
         it.vert_ok = vo;
         it.hop = 10'(h);
         it.span = s;
         it.span_ok = so;
         it.last = 1'b0;
         it.err = e;
         return it;
      endfunction

      function longint sat_diff(longint a, longint b);
         longint lo, hi;
         lo = 64'sh8000_0000_0000_0000;
         hi = 64'sh7fff_ffff_ffff_ffff;
         if (b > 0 && a < lo + b) return lo;
         if (b < 0 && a > hi + b) return hi;
         return a - b;
      endfunction

      function longint span_from(int s, int v);
         return max_mode ? sat_diff(wt[s], wt[v]) : sat_diff(wt[v], wt[s]);
      endfunction

      function void run_search(int s);
         int     bfs_q [$];
         int     order [$];
         int     rd [$];
         int     pushed, u, p, v, i, st, e, k, lv;
         bit     ok, rim, l_ok;
         longint sp, l_span;
         foreach (hop[n]) begin
            hop[n] = UNREACHED;
            in_basin[n] = 0;
            hb_ok[n] = 0;
            sp_ok[n] = 0;
         end
         l_ok = 0;
         lv = 0;
         l_span = 0;
         hop[s] = 0;
         pred[s] = s;
         in_basin[s] = 1;
         order.push_back(s);
         bfs_q.push_back(s);
         pushed = 1;
         while (bfs_q.size() > 0) begin
            u = bfs_q.pop_front();
            if (u != s) begin
               p = pred[u];
               ok = max_mode ? (wt[u] < wt[p]) : (wt[u] > wt[p]);
               if (!ok) begin
                  // violation: the predecessor marks the basin rim
                  sp = span_from(s, p);
                  sp_ok[p] = 1;
                  sp_val[p] = sp;
                  if (sp > 0 && (!l_ok || sp < l_span)) begin
                     l_ok = 1;
                     l_span = sp;
                     lv = p;
                  end
                  hb_ok[hop[p]] = 1;
                  hb_vert[hop[p]] = p;
                  continue;
               end
               in_basin[u] = 1;
               order.push_back(u);
            end
            for (int j = 0; j < deg[u]; j++) begin
               v = adj[u][j];
               if (hop[v] == UNREACHED && pushed < NV) begin
                  hop[v] = hop[u] + 1;
                  pred[v] = u;
                  bfs_q.push_back(v);
                  pushed++;
               end
            end
         end
         // leaves and vertices touching the outside are rim too
         foreach (order[n]) begin
            u = order[n];
            rim = (deg[u] == 1);
            for (int j = 0; !rim && j < deg[u]; j++)
               if (!in_basin[adj[u][j]]) rim = 1;
            if (rim) begin
               hb_ok[hop[u]] = 1;
               hb_vert[hop[u]] = u;
               sp_ok[u] = 1;
               sp_val[u] = span_from(s, u);
            end
         end
         // hops never decrease in search order: emit groups from the deepest
         i = order.size();
         while (i > 0) begin
            e = i;
            st = i - 1;
            while (st > 0 && hop[order[st-1]] == hop[order[e-1]]) st--;
            for (k = st; k < e; k++) rd.push_back(order[k]);
            i = st;
         end
         readout.delete();
         readout.push_back(mk(KIND_SUMMARY, l_ok ? lv : 0, l_ok, 0, wt[s], 1, 0));
         foreach (rd[n]) readout.push_back(mk(KIND_BASIN, rd[n], 1, hop[rd[n]], 0, 0, 0));
         for (int h = 0; h < NV; h++)
            if (hb_ok[h]) readout.push_back(mk(KIND_HOP, hb_vert[h], 1, h, 0, 0, 0));
         for (int n = 0; n < NV; n++)
            if (sp_ok[n]) readout.push_back(mk(KIND_SPAN, n, 1, hop[n], sp_val[n], 1, 0));
         readout[readout.size()-1].last = 1'b1;
      endfunction

      // Note one accepted request and queue whatever response it causes.
      function void note_request(logic [1:0] cmd, int vid, int nid, logic [31:0] dens,
                                 logic signed [31:0] fv);
         longint dl, fl;
         if (cmd == CMD_LOAD) begin
            dl = (dens == 0) ? 1 : dens;
            fl = fv;
            wt[vid] = fl * dl;
            deg[vid] = 0;
         end else if (cmd == CMD_APPEND) begin
            if (deg[vid] >= ND) expected.push_back(mk(0, 0, 0, 0, 0, 0, 1));
            else begin
               adj[vid][deg[vid]] = 10'(nid);
               deg[vid]++;
            end
         end else if (cmd == CMD_START) begin
            run_search(vid);
         end else if (readout.size() == 0) begin
            expected.push_back(mk(0, 0, 0, 0, 0, 0, 1));
         end else begin
            expected.push_back(readout.pop_front());
         end
      endfunction

      function void check_response(basin_item_t got);
         basin_item_t want;
         if (expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
            return;
         end
         want = expected.pop_front();
         if (got.kind !== want.kind || got.vert !== want.vert ||
             got.vert_ok !== want.vert_ok || got.hop !== want.hop ||
             got.span !== want.span || got.span_ok !== want.span_ok ||
             got.last !== want.last || got.err !== want.err) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm;
   int   cycles;
   int   sent;
   bit   loaded [NV];
   int   loaded_ids [$];
   basin_scoreboard sb;

   mbb_req_if req_ch ();
   mbb_rsp_if rsp_ch ();
   mbb_csr_if csr_ch ();

   monotone_basin_bfs u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Hold the run to a hard cycle cap.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("monotone_basin_bfs test failed");
         $finish;
      end
   end

   // Stall the response side at random except during calm stretches.
   always @(negedge clock) begin
      rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // Check every response taken at a rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_response({rsp_ch.item_kind, rsp_ch.out_vertex, rsp_ch.vertex_valid,
                            rsp_ch.out_hop, rsp_ch.out_span, rsp_ch.span_valid,
                            rsp_ch.last_item, rsp_ch.error_flag});
   end

   // Drive one request; enter and leave at a falling edge.
   task automatic send_req(logic [1:0] cmd, int vid, int nid, logic [31:0] dens,
                           logic signed [31:0] fv);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.command = cmd;
      req_ch.vertex_id = 10'(vid);
      req_ch.neighbor_id = 10'(nid);
      req_ch.density = dens;
      req_ch.fitted_value = fv;
      req_ch.valid = 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(cmd, vid, nid, dens, fv);
      sent++;
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task automatic load_vertex(int vid, logic [31:0] dens, logic signed [31:0] fv);
      send_req(CMD_LOAD, vid, $urandom_range(NV-1), dens, fv);
      if (!loaded[vid]) loaded_ids.push_back(vid);
      loaded[vid] = 1;
   endtask

   task automatic append_edge(int vid, int nid);
      send_req(CMD_APPEND, vid, nid, $urandom, $urandom);
   endtask

   task automatic read_next();
      send_req(CMD_READ, $urandom_range(NV-1), $urandom_range(NV-1), $urandom, $urandom);
   endtask

   task automatic start_search(int seed);
      send_req(CMD_START, seed, $urandom_range(NV-1), $urandom, $urandom);
   endtask

   // Pause the request side until every expected response is back, then let
   // the block settle.
   task automatic drain();
      while (sb.expected.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_mode(bit mode);
      drain();
      csr_ch.find_maximum = mode;
      csr_ch.valid = 1'b1;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      sb.max_mode = mode;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // One load / link / search / readout round over a small vertex set.
   task automatic run_round(bit mode, bit stuff);
      int          members [$];
      int          n, base_fv, step, pick, nread;
      logic [31:0] base_d;
      n = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(2, 20);
      base_d = ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 32'h20000);
      base_fv = $urandom_range(100000);
      step = $urandom_range(1, 400);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(NV-1);
         members.push_back(pick);
         // mostly a steady slope away from the seed, sometimes anything
         if ($urandom_range(99) < 15)
            load_vertex(pick, $urandom, $urandom);
         else if (mode)
            load_vertex(pick, base_d + $urandom_range(3),
                        base_fv - i * step - $urandom_range(step / 2));
         else
            load_vertex(pick, base_d + $urandom_range(3),
                        -base_fv + i * step + $urandom_range(step / 2));
      end
      for (int i = 0; i < n; i++) begin
         if (i + 1 < n && $urandom_range(99) < 80) append_edge(members[i], members[i+1]);
         repeat ($urandom_range(2)) begin
            if (sb.deg[members[i]] < ND) begin
               if ($urandom_range(7) == 0)
                  append_edge(members[i], loaded_ids[$urandom_range(loaded_ids.size()-1)]);
               else
                  append_edge(members[i], members[$urandom_range(n-1)]);
            end
         end
      end
      // overflow the list of one vertex
      if (stuff)
         while (sb.deg[members[0]] < ND + 1 && sent < ITEM_GOAL * 2) begin
            append_edge(members[0], members[$urandom_range(n-1)]);
            if (sb.deg[members[0]] == ND) begin
               append_edge(members[0], members[0]);
               break;
            end
         end
      if ($urandom_range(9) == 0) read_next();
      start_search(members[$urandom_range(1) ? 0 : $urandom_range(n-1)]);
      // sometimes abandon a readout halfway and search again
      if ($urandom_range(5) == 0) begin
         nread = sb.readout.size() / 2;
         repeat (nread) read_next();
         start_search(members[0]);
      end
      nread = sb.readout.size() + $urandom_range(2);
      repeat (nread) read_next();
   endtask

   initial begin
      int  rounds;
      bit  mode;
      sb = new();
      reset = 1'b1;
      calm = 1'b0;
      cycles = 0;
      sent = 0;
      req_ch.valid = 1'b0;
      req_ch.command = CMD_LOAD;
      req_ch.vertex_id = '0;
      req_ch.neighbor_id = '0;
      req_ch.density = '0;
      req_ch.fitted_value = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.find_maximum = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: read with nothing ready, extreme weights with saturating
      // spans, zero density, a leaf, then a read past the end.
      read_next();
      write_mode(1'b1);
      load_vertex(0, 32'hffff_ffff, 32'sh8000_0000);
      load_vertex(1023, 32'hffff_ffff, 32'sh7fff_ffff);
      load_vertex(5, 32'h0, 32'sd7);
      append_edge(0, 1023);
      append_edge(0, 5);
      append_edge(1023, 0);
      start_search(1023);
      repeat (sb.readout.size() + 1) read_next();
      write_mode(1'b0);
      start_search(0);
      repeat (sb.readout.size() + 1) read_next();

      // Random rounds; a calm stretch in the middle has no idling at all.
      rounds = 0;
      mode = 1'b0;
      while (sent < ITEM_GOAL) begin
         calm = (rounds >= 20 && rounds < 28);
         if (rounds % 4 == 0) begin
            mode = $urandom_range(1);
            write_mode(mode);
         end
         run_round(mode, $urandom_range(7) == 0);
         rounds++;
      end

      calm = 1'b0;
      drain();
      repeat (50) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected.size() == 0)
         $display("monotone_basin_bfs test passed");
      else
         $display("monotone_basin_bfs test failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/mbb_pkg.sv
rtl/core/mbb_if.sv
rtl/core/mbb_span.sv
rtl/core/monotone_basin_bfs.sv
rtl/core/mbb_checker.sv
test/monotone_basin_bfs_tb.sv
